FILE: design/alb_pkg.sv
// ============================================================================
// Ambient light backlight ramp package
// Shared types, register codes, reset values and widths.
// ============================================================================
package alb_pkg;

    // Fixed field widths
    localparam int LEVEL_W    = 8;
    localparam int THR_W      = 7;
    localparam int FS_W       = 12;
    localparam int SUM_W      = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int KIND_W     = 2;

    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [LEVEL_W-1:0] RESET_LEVEL = 8'd120;

    // Register reset values
    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST  = 8'd15;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = 8'd255;
    localparam logic [THR_W-1:0]   THRESHOLD_RST  = 7'd30;
    localparam logic [FS_W-1:0]    FULL_SCALE_RST = 12'd2900;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEVEL   = 3'd0,
        CFG_MAX_LEVEL   = 3'd1,
        CFG_THRESHOLD   = 3'd2,
        CFG_FULL_SCALE  = 3'd3,
        CFG_FADE_ENABLE = 3'd4
    } t_cfg_idx;

    // Kind of level update carried by a result
    typedef enum logic [KIND_W-1:0] {
        KIND_STEP = 2'd0,
        KIND_FADE = 2'd1,
        KIND_JUMP = 2'd2
    } t_kind;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_AVG,
        ST_CLAMP,
        ST_DECIDE
    } t_state;

    // Configuration register bank contents
    typedef struct packed {
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
        logic [THR_W-1:0]   jump_threshold;
        logic [FS_W-1:0]    full_scale_light;
        logic               fade_enable;
    } t_cfg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic acc;
        logic avg;
        logic clamp;
        logic decide;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic avg_due;
        logic need_emit;
        logic out_free;
    } t_dp_status;

endpackage

FILE: design/ambient_light_backlight_ramp_core.sv
// ============================================================================
// Ambient light backlight ramp core
// Scales light samples, averages them and steps, fades or jumps the level.
//
//   Channel   Direction  Handshake               Payload
//   --------  ---------  ----------------------  ---------------------------
//   sample    in         i_in_valid / o_in_stall i_light_sample
//   update    out        o_out_valid/i_out_stall o_update_kind, o_from_level,
//                                                o_to_level
//   config    in         i_cfg_wr_en             i_cfg_index, i_cfg_data
//
// A sample passes through the accepting step, DW serial divider steps, a done step and an
// accumulate step, DW = max(SENSOR_BITS + 8, 23). Every SAMPLES_PER_AVERAGE-th sample
// adds a reciprocal averaging step, a clamp step and a decision step; the decision
// waits while an earlier update is still held and stalled.
// Reset is synchronous and active low; no clearing pass is needed.
// A finished update waits in the output register; a second one stalls the decide step.
// ============================================================================
module ambient_light_backlight_ramp_core #(
    parameter int SAMPLES_PER_AVERAGE = 5,
    parameter int SENSOR_BITS         = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [SENSOR_BITS-1:0]            i_light_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [alb_pkg::KIND_W-1:0]        o_update_kind,
    output logic [alb_pkg::LEVEL_W-1:0]       o_from_level,
    output logic [alb_pkg::LEVEL_W-1:0]       o_to_level,
    input  logic                              i_cfg_wr_en,
    input  logic [alb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [alb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    alb_pkg::t_cfg       cfg;
    alb_pkg::t_dp_cmd    cmd;
    alb_pkg::t_dp_status status;

    // Configuration registers.
    alb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Sequencing state machine.
    alb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and state.
    alb_dp #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .SENSOR_BITS         (SENSOR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_light_sample (i_light_sample),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_update_kind  (o_update_kind),
        .o_from_level   (o_from_level),
        .o_to_level     (o_to_level)
    );

endmodule

FILE: design/alb_cfg.sv
// ============================================================================
// Configuration register bank
// Holds the five control registers written through the plain write port.
// ============================================================================
module alb_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [alb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [alb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output alb_pkg::t_cfg                     o_cfg
);

    alb_pkg::t_cfg r_cfg;
    alb_pkg::t_cfg n_cfg;

    // Decode the register index and update the addressed field.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (alb_pkg::t_cfg_idx'(i_cfg_index))
                alb_pkg::CFG_MIN_LEVEL: begin
                    n_cfg.min_level = i_cfg_data[alb_pkg::LEVEL_W-1:0];
                end
                alb_pkg::CFG_MAX_LEVEL: begin
                    n_cfg.max_level = i_cfg_data[alb_pkg::LEVEL_W-1:0];
                end
                alb_pkg::CFG_THRESHOLD: begin
                    n_cfg.jump_threshold = i_cfg_data[alb_pkg::THR_W-1:0];
                end
                alb_pkg::CFG_FULL_SCALE: begin
                    n_cfg.full_scale_light = i_cfg_data[alb_pkg::FS_W-1:0];
                end
                alb_pkg::CFG_FADE_ENABLE: begin
                    n_cfg.fade_enable = i_cfg_data[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_level        <= alb_pkg::MIN_LEVEL_RST;
            r_cfg.max_level        <= alb_pkg::MAX_LEVEL_RST;
            r_cfg.jump_threshold   <= alb_pkg::THRESHOLD_RST;
            r_cfg.full_scale_light <= alb_pkg::FULL_SCALE_RST;
            r_cfg.fade_enable      <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/alb_ctrl.sv
// ============================================================================
// Backlight ramp controller
// Sequences scaling, accumulation, averaging and the level decision.
// ============================================================================
module alb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  alb_pkg::t_dp_status  i_status,
    output alb_pkg::t_dp_cmd     o_cmd
);

    alb_pkg::t_state r_state;
    alb_pkg::t_state n_state;

    // Next state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alb_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = alb_pkg::ST_DIV;
            end
            alb_pkg::ST_DIV: begin
                if (i_status.div_done) n_state = alb_pkg::ST_ACC;
            end
            alb_pkg::ST_ACC: begin
                n_state = i_status.avg_due ? alb_pkg::ST_AVG : alb_pkg::ST_IDLE;
            end
            alb_pkg::ST_AVG: begin
                n_state = alb_pkg::ST_CLAMP;
            end
            alb_pkg::ST_CLAMP: begin
                n_state = alb_pkg::ST_DECIDE;
            end
            alb_pkg::ST_DECIDE: begin
                if (!i_status.need_emit || i_status.out_free) n_state = alb_pkg::ST_IDLE;
            end
            default: begin
                n_state = alb_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            alb_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            alb_pkg::ST_DIV: begin
                o_cmd.div_step = !i_status.div_done;
            end
            alb_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
            end
            alb_pkg::ST_AVG: begin
                o_cmd.avg = 1'b1;
            end
            alb_pkg::ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
            end
            alb_pkg::ST_DECIDE: begin
                o_cmd.decide = !i_status.need_emit || i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/alb_dp.sv
// ============================================================================
// Backlight ramp datapath
// Scaling multiplier, restoring divider, reciprocal averaging, sum, level and
// result register.
// ============================================================================
module alb_dp #(
    parameter int SAMPLES_PER_AVERAGE = 5,
    parameter int SENSOR_BITS         = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [SENSOR_BITS-1:0]            i_light_sample,
    input  alb_pkg::t_cfg                     i_cfg,
    input  alb_pkg::t_dp_cmd                  i_cmd,
    output alb_pkg::t_dp_status               o_status,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [alb_pkg::KIND_W-1:0]        o_update_kind,
    output logic [alb_pkg::LEVEL_W-1:0]       o_from_level,
    output logic [alb_pkg::LEVEL_W-1:0]       o_to_level
);

    localparam int PROD_W = SENSOR_BITS + alb_pkg::LEVEL_W;
    localparam int DW     = (PROD_W > alb_pkg::SUM_W) ? PROD_W : alb_pkg::SUM_W;
    localparam int CNT_W  = $clog2(DW + 1);
    localparam int SC_W   = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam int RW     = alb_pkg::FS_W;

    // Averaging by reciprocal multiplication: floor(sum * M / 2^AVG_SH) equals
    // floor(sum / SAMPLES_PER_AVERAGE) for every sum below 2^SUM_W.
    localparam int          AVG_SH    = alb_pkg::SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int          RECIP_W   = alb_pkg::SUM_W + 1;
    localparam int          AVG_PW    = alb_pkg::SUM_W + RECIP_W;
    localparam logic [63:0] AVG_RECIP = ((64'd1 << AVG_SH) + 64'(SAMPLES_PER_AVERAGE - 1))
                                        / 64'(SAMPLES_PER_AVERAGE);

    // Divider registers
    logic [DW-1:0]    r_quo;
    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    r_divisor;
    logic [CNT_W-1:0] r_bit_cnt;

    // Block state
    logic [alb_pkg::SUM_W-1:0]   r_sum;
    logic [SC_W-1:0]             r_count;
    logic [alb_pkg::LEVEL_W-1:0] r_level;
    logic [alb_pkg::LEVEL_W-1:0] r_target;

    // Result register
    logic                        r_out_valid;
    alb_pkg::t_kind              r_kind;
    logic [alb_pkg::LEVEL_W-1:0] r_from;
    logic [alb_pkg::LEVEL_W-1:0] r_to;

    logic [PROD_W-1:0]           product;
    logic [RW-1:0]               divisor_in;
    logic [RW:0]                 rem_shift;
    logic                        quo_bit;
    logic [DW:0]                 sum_wide;
    logic [alb_pkg::SUM_W-1:0]   sum_sat;
    logic                        avg_due;
    logic [AVG_PW-1:0]           avg_prod;
    logic [DW-1:0]               floor_val;
    logic [alb_pkg::LEVEL_W-1:0] clamp_val;
    logic                        go_up;
    logic [alb_pkg::LEVEL_W-1:0] diff;
    logic                        big;
    logic                        small_step;
    logic                        out_free;

    // Scaling product and divisor, with a zero full scale read as one.
    assign product    = PROD_W'(i_light_sample) * PROD_W'(i_cfg.max_level);
    assign divisor_in = (i_cfg.full_scale_light == '0) ? RW'(1) : i_cfg.full_scale_light;

    // One restoring division step per cycle.
    assign rem_shift = {r_rem, r_quo[DW-1]};
    assign quo_bit   = (rem_shift >= {1'b0, r_divisor});

    // Saturating accumulation of the scaled sample.
    assign sum_wide = (DW+1)'(r_sum) + (DW+1)'(r_quo);
    assign sum_sat  = (sum_wide > (DW+1)'(alb_pkg::SUM_MAX)) ? alb_pkg::SUM_MAX
                                                             : sum_wide[alb_pkg::SUM_W-1:0];
    assign avg_due  = (r_count == SC_W'(SAMPLES_PER_AVERAGE - 1));

    // Product of the held sum and the reciprocal of the sample count.
    assign avg_prod = AVG_PW'(r_quo[alb_pkg::SUM_W-1:0]) * AVG_PW'(AVG_RECIP[RECIP_W-1:0]);

    // Clamp the average up to the minimum, then down to the maximum.
    assign floor_val = (r_quo < DW'(i_cfg.min_level)) ? DW'(i_cfg.min_level) : r_quo;
    assign clamp_val = (floor_val > DW'(i_cfg.max_level)) ? i_cfg.max_level
                                                          : floor_val[alb_pkg::LEVEL_W-1:0];

    // Level comparison against the registered target.
    assign go_up      = (r_target > r_level);
    assign diff       = go_up ? (r_target - r_level) : (r_level - r_target);
    assign big        = (diff > 8'd1);
    assign small_step = big && (diff <= {1'b0, i_cfg.jump_threshold});
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status           = '0;
        o_status.div_done  = (r_bit_cnt == '0);
        o_status.avg_due   = avg_due;
        o_status.need_emit = big;
        o_status.out_free  = out_free;
    end

    // Divider, average and target registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo     <= DW'(product);
            r_rem     <= '0;
            r_divisor <= divisor_in;
            r_bit_cnt <= CNT_W'(DW);
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[DW-2:0], quo_bit};
            r_rem     <= quo_bit ? RW'(rem_shift - {1'b0, r_divisor}) : rem_shift[RW-1:0];
            r_bit_cnt <= r_bit_cnt - 1'b1;
        end else if (i_cmd.acc && avg_due) begin
            r_quo     <= DW'(sum_sat);
        end else if (i_cmd.avg) begin
            r_quo     <= DW'(avg_prod >> AVG_SH);
        end
        if (i_cmd.clamp) begin
            r_target <= clamp_val;
        end
    end

    // Running sum, sample count and current level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_level <= alb_pkg::RESET_LEVEL;
        end else begin
            if (i_cmd.acc) begin
                if (avg_due) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= sum_sat;
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.decide) begin
                if (small_step) begin
                    r_level <= go_up ? (r_level + 1'b1) : (r_level - 1'b1);
                end else begin
                    r_level <= r_target;
                end
            end
        end
    end

    // Result register; a new transaction loads only when the previous one has left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.decide && big) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && big) begin
            r_from <= r_level;
            if (small_step) begin
                r_kind <= alb_pkg::KIND_STEP;
                r_to   <= go_up ? (r_level + 1'b1) : (r_level - 1'b1);
            end else begin
                r_kind <= i_cfg.fade_enable ? alb_pkg::KIND_FADE : alb_pkg::KIND_JUMP;
                r_to   <= r_target;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_update_kind = r_kind;
    assign o_from_level  = r_from;
    assign o_to_level    = r_to;

endmodule

FILE: design/alb_checker.sv
// ============================================================================
// Backlight ramp port checker
// Watches the top-level ports for handshake and result consistency.
// ============================================================================
module alb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [alb_pkg::KIND_W-1:0]   o_update_kind,
    input logic [alb_pkg::LEVEL_W-1:0]  o_from_level,
    input logic [alb_pkg::LEVEL_W-1:0]  o_to_level
);

    // The core works on one sample at a time, so it is busy right after a transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sample accepted while the previous one was still in work");

    // A stalled update holds its valid and payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_update_kind)
            && $stable(o_from_level) && $stable(o_to_level)))
        else $error("stalled update changed");

    // A single step moves the level by exactly one.
    a_step_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_update_kind == alb_pkg::KIND_STEP) |->
            (({1'b0, o_to_level} == {1'b0, o_from_level} + 9'd1) ||
             ({1'b0, o_from_level} == {1'b0, o_to_level} + 9'd1)))
        else $error("single step update does not move by one level");

    // A fade or jump always changes the level by more than one.
    a_big_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_update_kind == alb_pkg::KIND_FADE ||
                         o_update_kind == alb_pkg::KIND_JUMP)) |->
            (({1'b0, o_to_level} > {1'b0, o_from_level} + 9'd1) ||
             ({1'b0, o_from_level} > {1'b0, o_to_level} + 9'd1)))
        else $error("fade or jump update with a difference of one or less");

    // Only the three defined update kinds appear.
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_update_kind == alb_pkg::KIND_STEP ||
                         o_update_kind == alb_pkg::KIND_FADE ||
                         o_update_kind == alb_pkg::KIND_JUMP))
        else $error("undefined update kind on a valid update");

endmodule

bind ambient_light_backlight_ramp_core alb_checker u_alb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_update_kind (o_update_kind),
    .o_from_level  (o_from_level),
    .o_to_level    (o_to_level)
);

FILE: tb/sv/ambient_light_backlight_ramp_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Ambient light backlight ramp core testbench
// Feeds light samples through the valid/stall channel, mirrors the scaling,
// averaging, clamping and level decision in a local level tracker, and checks
// every update transaction field by field. Directed groups come first, then
// random groups under many register settings, with random idling on both
// sides of the block.
// ============================================================================
module ambient_light_backlight_ramp_core_tb;

    localparam int SAMPLES_PER_AVERAGE = 5;
    localparam int SENSOR_BITS         = 12;
    localparam int RANDOM_PHASES       = 12;
    localparam int PHASE_SAMPLES       = 95;
    // Allow a generous margin beyond the time an average takes.
    localparam int SETTLE_CYCLES       = 150;
    localparam int WATCHDOG_LIMIT      = 3000;
    localparam logic [alb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // One update transaction as the block should report it.
    typedef struct {
        alb_pkg::t_kind              kind;
        logic [alb_pkg::LEVEL_W-1:0] from_lvl;
        logic [alb_pkg::LEVEL_W-1:0] to_lvl;
    } t_level_update;

    // Clock, reset and block inputs, all known from time zero.
    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_in_valid     = 1'b0;
    logic [SENSOR_BITS-1:0]            i_light_sample = '0;
    logic                              i_out_stall    = 1'b0;
    logic                              i_cfg_wr_en    = 1'b0;
    logic [alb_pkg::CFG_IDX_W-1:0]     i_cfg_index    = '0;
    logic [alb_pkg::CFG_DATA_W-1:0]    i_cfg_data     = '0;

    logic                              o_in_stall;
    logic                              o_out_valid;
    logic [alb_pkg::KIND_W-1:0]        o_update_kind;
    logic [alb_pkg::LEVEL_W-1:0]       o_from_level;
    logic [alb_pkg::LEVEL_W-1:0]       o_to_level;

    // Mirror of the register bank and of the level tracking state.
    logic [alb_pkg::LEVEL_W-1:0]     lvl_min      = alb_pkg::MIN_LEVEL_RST;
    logic [alb_pkg::LEVEL_W-1:0]     lvl_max      = alb_pkg::MAX_LEVEL_RST;
    logic [alb_pkg::THR_W-1:0]       lvl_thr      = alb_pkg::THRESHOLD_RST;
    logic [alb_pkg::FS_W-1:0]        full_scale   = alb_pkg::FULL_SCALE_RST;
    logic                            fade_on      = 1'b1;
    logic [alb_pkg::LEVEL_W-1:0]     backlight    = alb_pkg::RESET_LEVEL;
    logic [alb_pkg::SUM_W-1:0]       light_sum    = '0;
    int unsigned                     light_count  = 0;

    t_level_update          expected_updates[$];

    int unsigned            mismatch_count = 0;
    int unsigned            samples_sent   = 0;
    int unsigned            settings_used  = 1;
    int unsigned            steps_seen     = 0;
    int unsigned            fades_seen     = 0;
    int unsigned            jumps_seen     = 0;
    int unsigned            silent_seen    = 0;
    int unsigned            stall_left     = 0;
    int unsigned            idle_cycles    = 0;
    bit                     calm           = 1'b0;

    ambient_light_backlight_ramp_core #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .SENSOR_BITS         (SENSOR_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_light_sample (i_light_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_update_kind  (o_update_kind),
        .o_from_level   (o_from_level),
        .o_to_level     (o_to_level),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Free-running clock.
    always #5 i_clk = ~i_clk;

    // Scale one sample into the running sum and, on every fifth sample,
    // decide the level update that the block must report.
    task automatic track_level(input logic [SENSOR_BITS-1:0] sample);
        logic [63:0]                 divisor;
        logic [63:0]                 scaled;
        logic [63:0]                 total;
        logic [63:0]                 goal;
        logic [alb_pkg::LEVEL_W-1:0] target;
        int unsigned                 diff;
        t_level_update               upd;
        divisor = (full_scale == '0) ? 64'd1 : 64'(full_scale);
        scaled  = 64'(sample) * 64'(lvl_max) / divisor;
        total   = 64'(light_sum) + scaled;
        light_sum = (total > 64'(alb_pkg::SUM_MAX)) ? alb_pkg::SUM_MAX
                                                    : total[alb_pkg::SUM_W-1:0];
        light_count++;
        if (light_count >= SAMPLES_PER_AVERAGE) begin
            // Average, then clamp up to the minimum and down to the maximum.
            goal = 64'(light_sum) / SAMPLES_PER_AVERAGE;
            if (goal < 64'(lvl_min)) begin
                goal = 64'(lvl_min);
            end
            if (goal > 64'(lvl_max)) begin
                goal = 64'(lvl_max);
            end
            target = goal[alb_pkg::LEVEL_W-1:0];
            diff = (backlight > target) ? backlight - target : target - backlight;
            upd.from_lvl = backlight;
            if (diff > 1 && diff <= lvl_thr) begin
                upd.kind   = alb_pkg::KIND_STEP;
                upd.to_lvl = (backlight < target) ? backlight + 1'b1 : backlight - 1'b1;
                steps_seen++;
                expected_updates.push_back(upd);
            end else if (diff > 1) begin
                upd.kind   = fade_on ? alb_pkg::KIND_FADE : alb_pkg::KIND_JUMP;
                upd.to_lvl = target;
                if (fade_on) begin
                    fades_seen++;
                end else begin
                    jumps_seen++;
                end
                expected_updates.push_back(upd);
            end else begin
                upd.to_lvl = target;
                silent_seen++;
            end
            backlight   = upd.to_lvl;
            light_sum   = '0;
            light_count = 0;
        end
    endtask

    // Sender idle gap: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offer one sample and return at the edge where it is accepted.
    task automatic send_sample(input logic [SENSOR_BITS-1:0] sample);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_light_sample <= sample;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        track_level(sample);
        samples_sent++;
    endtask

    // Stop sending and let every outstanding update come out.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle and mirror it locally.
    task automatic write_reg(input logic [alb_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[alb_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            alb_pkg::CFG_MIN_LEVEL:   lvl_min    = value[alb_pkg::LEVEL_W-1:0];
            alb_pkg::CFG_MAX_LEVEL:   lvl_max    = value[alb_pkg::LEVEL_W-1:0];
            alb_pkg::CFG_THRESHOLD:   lvl_thr    = value[alb_pkg::THR_W-1:0];
            alb_pkg::CFG_FULL_SCALE:  full_scale = value[alb_pkg::FS_W-1:0];
            alb_pkg::CFG_FADE_ENABLE: fade_on    = value[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int unsigned min_v, input int unsigned max_v,
                             input int unsigned thr_v, input int unsigned fs_v,
                             input int unsigned fade_v);
        write_reg(alb_pkg::CFG_MIN_LEVEL, min_v);
        write_reg(alb_pkg::CFG_MAX_LEVEL, max_v);
        write_reg(alb_pkg::CFG_THRESHOLD, thr_v);
        write_reg(alb_pkg::CFG_FULL_SCALE, fs_v);
        write_reg(alb_pkg::CFG_FADE_ENABLE, fade_v);
        settings_used++;
    endtask

    task automatic send_repeated(input logic [SENSOR_BITS-1:0] sample, input int unsigned n);
        repeat (n) send_sample(sample);
    endtask

    // Reset settings: full-scale samples fade the level up to the maximum.
    task automatic test_reset_defaults();
        send_repeated('1, SAMPLES_PER_AVERAGE);
        settle();
    endtask

    // One-to-one scaling: fade down to the minimum, one step, then a
    // difference of one that is taken silently.
    task automatic test_step_and_silent();
        write_all(1, 255, 30, 255, 1);
        send_repeated('0, SAMPLES_PER_AVERAGE);
        send_repeated(SENSOR_BITS'(3), SAMPLES_PER_AVERAGE);
        send_repeated(SENSOR_BITS'(3), SAMPLES_PER_AVERAGE);
        settle();
    endtask

    // Fading off, zero threshold, zero full scale and a minimum above the
    // maximum: the clamp lands on the maximum and the level jumps there.
    task automatic test_jump_and_odd_config();
        write_all(200, 100, 0, 0, 0);
        send_repeated(SENSOR_BITS'(1), SAMPLES_PER_AVERAGE);
        settle();
    endtask

    // Sample that scales to roughly the given level under the current setting.
    function automatic logic [SENSOR_BITS-1:0] sample_for_level(input int unsigned lvl);
        int unsigned div;
        int unsigned raw;
        div = (full_scale == '0) ? 1 : full_scale;
        if (lvl_max == '0) begin
            return SENSOR_BITS'($urandom_range(0, (1 << SENSOR_BITS) - 1));
        end
        raw = (lvl * div + lvl_max - 1) / lvl_max;
        return (raw > (1 << SENSOR_BITS) - 1) ? '1 : raw[SENSOR_BITS-1:0];
    endfunction

    // One averaging group: half the time aimed near the current level so that
    // steps, silent updates and threshold edges all occur.
    task automatic send_group();
        int unsigned mode;
        int          reach;
        int          lvl;
        logic [SENSOR_BITS-1:0] base;
        logic [SENSOR_BITS-1:0] pick;
        mode  = $urandom_range(0, 9);
        reach = int'(lvl_thr) + 3;
        if ($urandom_range(0, 1) == 0) begin
            lvl = int'(backlight) + int'($urandom_range(0, 6)) - 3;
        end else begin
            lvl = int'(backlight) + int'($urandom_range(0, 2 * reach)) - reach;
        end
        if (lvl < 0) begin
            lvl = 0;
        end
        if (lvl > 255) begin
            lvl = 255;
        end
        base = (mode == 9) ? SENSOR_BITS'($urandom_range(0, (1 << SENSOR_BITS) - 1))
                           : sample_for_level(lvl);
        repeat (SAMPLES_PER_AVERAGE) begin
            if (mode < 5 || mode == 9) begin
                pick = base;
            end else if (mode < 8) begin
                pick = SENSOR_BITS'($urandom_range(0, (1 << SENSOR_BITS) - 1));
            end else begin
                pick = ($urandom_range(0, 1) == 0) ? '0 : '1;
            end
            send_sample(pick);
        end
    endtask

    // Random groups under many settings, extremes first.
    task automatic test_random_settings();
        int unsigned phase;
        int unsigned sent_here;
        int unsigned max_v;
        int unsigned min_v;
        int unsigned thr_v;
        int unsigned fs_v;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm = ($urandom_range(0, 3) == 0);
            case (phase)
                0: write_all(1, 255, 100, 3000, 1);
                1: write_all(255, 255, 1, 1, 0);
                2: write_all(1, 255, 0, 255, 1);
                3: write_all(1, 1, 127, 4095, 0);
                default: begin
                    max_v = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) == 0) ? 1 : 255)
                                                       : $urandom_range(1, 255);
                    min_v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(1, max_v);
                    thr_v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(1, 100);
                    fs_v  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(1, 3000);
                    write_all(min_v, max_v, thr_v, fs_v, $urandom_range(0, 1));
                end
            endcase
            // A write to an index with no register must change nothing.
            if (phase == 5) begin
                write_reg(CFG_UNUSED, $urandom_range(0, (1 << alb_pkg::CFG_DATA_W) - 1));
            end
            sent_here = 0;
            while (sent_here < PHASE_SAMPLES) begin
                send_group();
                sent_here += SAMPLES_PER_AVERAGE;
            end
            settle();
        end
        calm = 1'b0;
    endtask

    // Receiver stall: mostly free, short stalls, now and then a long one.
    always @(posedge i_clk) begin
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (calm || roll < 60) begin
            i_out_stall <= 1'b0;
        end else if (roll < 92) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(15, 60);
        end
    end

    // Compare each update transaction with the oldest expected one.
    always @(posedge i_clk) begin
        t_level_update want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_updates.size() == 0) begin
                $error("unexpected update: kind %0d from %0d to %0d",
                       o_update_kind, o_from_level, o_to_level);
                mismatch_count++;
            end else begin
                want = expected_updates.pop_front();
                if (o_update_kind !== want.kind) begin
                    $error("update_kind: expected %0d, actual %0d", want.kind, o_update_kind);
                    mismatch_count++;
                end
                if (o_from_level !== want.from_lvl) begin
                    $error("from_level: expected %0d, actual %0d", want.from_lvl, o_from_level);
                    mismatch_count++;
                end
                if (o_to_level !== want.to_lvl) begin
                    $error("to_level: expected %0d, actual %0d", want.to_lvl, o_to_level);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("ambient_light_backlight_ramp_core_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_step_and_silent();
        test_jump_and_odd_config();
        test_random_settings();
        $display("Sent %0d light samples under %0d register settings.",
                 samples_sent, settings_used);
        $display("Checked %0d steps, %0d fades, %0d jumps; %0d averages were silent.",
                 steps_seen, fades_seen, jumps_seen, silent_seen);
        if (mismatch_count == 0) begin
            $display("ambient_light_backlight_ramp_core_tb passed");
        end else begin
            $display("ambient_light_backlight_ramp_core_tb failed");
        end
        $finish;
    end

endmodule
